>>> design/aer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aer_pkg: shared constants of the ARP and ICMP echo responder
// Protocol codes, status codes and frame layout sizes.
// ----------------------------------------------------------------------------
package aer_pkg;

  // Ethertypes and protocol codes.
  localparam logic [15:0] ETH_ARP            = 16'h0806;
  localparam logic [15:0] ETH_IPV4           = 16'h0800;
  localparam logic [15:0] ARP_REQUEST        = 16'h0001;
  localparam logic [15:0] ARP_REPLY          = 16'h0002;
  localparam logic [7:0]  PROTO_ICMP         = 8'h01;
  localparam logic [7:0]  ICMP_ECHO_REQUEST  = 8'h08;
  localparam logic [7:0]  ICMP_ECHO_REPLY    = 8'h00;
  localparam logic [31:0] LOCAL_IP_RESET     = 32'h0A00_020F;

  // Header bytes that are captured and rewritten.
  localparam int HDR_BYTES = 42;
  // Smallest frame that holds an ARP or IPv4 plus ICMP header.
  localparam int MIN_FRAME = 42;
  // First byte of the ICMP message.
  localparam int ICMP_START = 34;

  // Result status codes.
  localparam logic [2:0] STATUS_NONE  = 3'd0;
  localparam logic [2:0] STATUS_ARP   = 3'd1;
  localparam logic [2:0] STATUS_ECHO  = 3'd2;
  localparam logic [2:0] STATUS_NOTED = 3'd3;
  localparam logic [2:0] STATUS_DROP  = 3'd4;

  // Register addresses on the configuration port.
  localparam logic REG_LOCAL_IP  = 1'b0;
  localparam logic REG_LOCAL_MAC = 1'b1;

endpackage

>>> design/aer_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aer_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module aer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/arp_icmp_echo_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder: ARP and ICMP echo responder
// Buffers a received frame, answers ARP requests and ICMP echo requests in
// place, and hands the reply back one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one transfer per byte: mode 0 pushes rx_byte into
// the frame buffer, mode 1 pulls the next reply byte. Every input transfer
// yields exactly one output transfer with the reply byte, status and flags.
// A pushed byte that is not the last of its frame goes straight to the output
// state, as does a pull with nothing pending; a pull of a pending byte first
// passes through a registered memory read. The last byte of a frame runs the
// frame sequencer: it captures the header from the frame buffer, decodes it,
// for an echo request sums the ICMP bytes and folds the checksums, and then
// writes the new header back; all of it is bound by the single read and write
// port of the frame buffer. Reset clears all control state and flags; the frame
// buffer is not cleared, as only bytes of the current frame are ever read.
// While the receiver stalls, the finished result waits in the output register
// and the block still takes the next input transfer, but holds further results.
// local_ip sits at address 0 and local_mac at address 8 of the APB port.
// ----------------------------------------------------------------------------
module arp_icmp_echo_responder
  import aer_pkg::*;
#(
  parameter int BUFFER_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic [2:0]  status_o,
  output logic        reply_pending_o,
  output logic        ping_seen_o,
  output logic [31:0] ping_source_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = AW + 1;
  localparam int SW = CW + 16;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_DEC, S_SUM, S_FOLD, S_WB, S_PULL, S_OUT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic          cap_q;
  logic [CW-1:0] cap_idx_q;
  logic [CW-1:0] wc_q;
  logic          ovf_q;
  logic [CW-1:0] rl_q;
  logic [CW-1:0] rp_q;
  logic [CW-1:0] len_q;
  logic          ping_flag_q;
  logic [31:0]   ping_addr_q;
  logic [31:0]   local_ip_q;
  logic [47:0]   local_mac_q;
  logic [7:0]    res_tx_q;
  logic          res_last_q;
  logic [2:0]    res_status_q;
  logic          out_valid_q;
  logic [7:0]    out_tx_q;
  logic          out_last_q;
  logic [2:0]    out_status_q;
  logic          out_pend_q;
  logic          out_seen_q;
  logic [31:0]   out_src_q;

  logic [7:0]    img_q [HDR_BYTES];
  logic [SW-1:0] icmp_acc_q;
  logic [SW-1:0] ip_acc_q;

  logic          accept;
  logic          wr_ok;
  logic          ovf_now;
  logic [CW-1:0] len_now;
  logic          issue;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [15:0]   eth_type;
  logic          arp_hit;
  logic          is_icmp;
  logic          echo_req;
  logic          echo_rep;
  logic [7:0]    sum_byte;
  logic [SW-1:0] sum_term;
  logic          ip_word;
  logic [SW-1:0] ip_term;
  logic          fold_done;
  logic          cfg_write;

  // Handshake and buffer fill decisions.
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign wr_ok      = (wc_q < CW'(BUFFER_BYTES));
  assign ovf_now    = ovf_q || !wr_ok;
  assign len_now    = wr_ok ? (wc_q + CW'(1)) : wc_q;
  assign issue      = ((state_q == S_HDR) && (cnt_q < CW'(HDR_BYTES))) ||
                      ((state_q == S_SUM) && (cnt_q < len_q));

  // Frame buffer port selection.
  always_comb begin
    if (state_q == S_WB) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[AW-1:0];
      mem_wdata = img_q[0];
    end else begin
      mem_we    = accept && !mode_i && wr_ok;
      mem_waddr = wc_q[AW-1:0];
      mem_wdata = rx_byte_i;
    end
  end
  assign mem_raddr = (state_q == S_IDLE) ? rp_q[AW-1:0] : cnt_q[AW-1:0];

  aer_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Frame classification from the captured header.
  assign eth_type = {img_q[12], img_q[13]};
  assign arp_hit  = (eth_type == ETH_ARP) && ({img_q[20], img_q[21]} == ARP_REQUEST) &&
                    ({img_q[38], img_q[39], img_q[40], img_q[41]} == local_ip_q);
  assign is_icmp  = (eth_type == ETH_IPV4) && (img_q[23] == PROTO_ICMP);
  assign echo_req = is_icmp && (img_q[34] == ICMP_ECHO_REQUEST);
  assign echo_rep = is_icmp && (img_q[34] == ICMP_ECHO_REPLY);

  // ICMP sum term: the type and checksum bytes count as zero.
  always_comb begin
    if ((cap_idx_q == CW'(ICMP_START)) || (cap_idx_q == CW'(ICMP_START + 2)) ||
        (cap_idx_q == CW'(ICMP_START + 3))) begin
      sum_byte = 8'h00;
    end else begin
      sum_byte = mem_rdata;
    end
  end
  assign sum_term = cap_idx_q[0] ? SW'(sum_byte) : SW'({sum_byte, 8'h00});

  // IPv4 header sum term: bytes 14 to 33 without the checksum field.
  assign ip_word = (cap_idx_q >= CW'(14)) && (cap_idx_q <= CW'(33)) &&
                   (cap_idx_q != CW'(24)) && (cap_idx_q != CW'(25));
  assign ip_term = !ip_word ? '0 :
                   (cap_idx_q[0] ? SW'(mem_rdata) : SW'({mem_rdata, 8'h00}));

  assign fold_done = (icmp_acc_q[SW-1:16] == '0) && (ip_acc_q[SW-1:16] == '0);

  // Configuration port.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[3] == REG_LOCAL_MAC) ? {16'h0000, local_mac_q}
                                                 : {32'h0000_0000, local_ip_q};

  // Sequencer, frame counters, flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      cap_q        <= 1'b0;
      cap_idx_q    <= '0;
      wc_q         <= '0;
      ovf_q        <= 1'b0;
      rl_q         <= '0;
      rp_q         <= '0;
      len_q        <= '0;
      ping_flag_q  <= 1'b0;
      ping_addr_q  <= '0;
      local_ip_q   <= LOCAL_IP_RESET;
      local_mac_q  <= '0;
      res_tx_q     <= '0;
      res_last_q   <= 1'b0;
      res_status_q <= STATUS_NONE;
      out_valid_q  <= 1'b0;
      out_tx_q     <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= STATUS_NONE;
      out_pend_q   <= 1'b0;
      out_seen_q   <= 1'b0;
      out_src_q    <= '0;
    end else begin
      if (cfg_write) begin
        if (paddr[3] == REG_LOCAL_MAC) begin
          local_mac_q <= pwdata[47:0];
        end else begin
          local_ip_q <= pwdata[31:0];
        end
      end
      cap_q     <= issue;
      cap_idx_q <= cnt_q;
      // The output register empties unless a new result is loaded below.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_tx_q   <= '0;
            res_last_q <= 1'b0;
            if (!mode_i) begin
              // The first byte of a new frame cancels an unfinished reply.
              if ((wc_q == '0) && !ovf_q) begin
                rl_q <= '0;
                rp_q <= '0;
              end
              if (rx_last_i) begin
                len_q <= len_now;
                wc_q  <= '0;
                ovf_q <= 1'b0;
                if (ovf_now || (len_now < CW'(MIN_FRAME))) begin
                  res_status_q <= STATUS_DROP;
                  state_q      <= S_OUT;
                end else begin
                  res_status_q <= STATUS_NONE;
                  cnt_q        <= '0;
                  state_q      <= S_HDR;
                end
              end else begin
                res_status_q <= STATUS_NONE;
                state_q      <= S_OUT;
                if (wr_ok) begin
                  wc_q <= wc_q + CW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
            end else begin
              res_status_q <= STATUS_NONE;
              state_q      <= (rp_q < rl_q) ? S_PULL : S_OUT;
            end
          end
        end
        S_HDR: begin
          if (cnt_q < CW'(HDR_BYTES)) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (cap_q && (cap_idx_q == CW'(HDR_BYTES - 1))) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (arp_hit) begin
            res_status_q <= STATUS_ARP;
            cnt_q        <= '0;
            state_q      <= S_WB;
          end else if (echo_req) begin
            res_status_q <= STATUS_ECHO;
            cnt_q        <= CW'(ICMP_START);
            state_q      <= S_SUM;
          end else if (echo_rep) begin
            ping_addr_q  <= {img_q[26], img_q[27], img_q[28], img_q[29]};
            ping_flag_q  <= 1'b1;
            res_status_q <= STATUS_NOTED;
            state_q      <= S_OUT;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_SUM: begin
          if (cnt_q < len_q) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (cap_q && (cap_idx_q == (len_q - CW'(1)))) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (fold_done) begin
            cnt_q   <= '0;
            state_q <= S_WB;
          end
        end
        S_WB: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(HDR_BYTES - 1)) begin
            rl_q    <= len_q;
            rp_q    <= '0;
            state_q <= S_OUT;
          end
        end
        S_PULL: begin
          res_tx_q   <= mem_rdata;
          res_last_q <= ((rp_q + CW'(1)) == rl_q);
          rp_q       <= rp_q + CW'(1);
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_tx_q     <= res_tx_q;
            out_last_q   <= res_last_q;
            out_status_q <= res_status_q;
            out_pend_q   <= (rp_q < rl_q);
            out_seen_q   <= ping_flag_q;
            out_src_q    <= ping_addr_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Header image and checksum accumulators.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ip_acc_q <= '0;
      end
      S_HDR: begin
        if (cap_q) begin
          for (int k = 0; k < HDR_BYTES - 1; k++) begin
            img_q[k] <= img_q[k+1];
          end
          img_q[HDR_BYTES-1] <= mem_rdata;
          ip_acc_q <= ip_acc_q + ip_term;
        end
      end
      S_DEC: begin
        icmp_acc_q <= '0;
        // Destination MAC takes the old source, source MAC becomes ours.
        if (arp_hit || echo_req) begin
          for (int k = 0; k < 6; k++) begin
            img_q[k]   <= img_q[6+k];
            img_q[6+k] <= local_mac_q[8*(5-k) +: 8];
          end
        end
        if (arp_hit) begin
          img_q[20] <= ARP_REPLY[15:8];
          img_q[21] <= ARP_REPLY[7:0];
          for (int k = 0; k < 6; k++) begin
            img_q[22+k] <= local_mac_q[8*(5-k) +: 8];
            img_q[32+k] <= img_q[22+k];
          end
          for (int k = 0; k < 4; k++) begin
            img_q[28+k] <= local_ip_q[8*(3-k) +: 8];
            img_q[38+k] <= img_q[28+k];
          end
        end else if (echo_req) begin
          for (int k = 0; k < 4; k++) begin
            img_q[26+k] <= img_q[30+k];
            img_q[30+k] <= img_q[26+k];
          end
          img_q[ICMP_START] <= ICMP_ECHO_REPLY;
        end
      end
      S_SUM: begin
        if (cap_q) begin
          icmp_acc_q <= icmp_acc_q + sum_term;
        end
      end
      S_FOLD: begin
        // End-around carry folding, then the complemented sums go in.
        if (!fold_done) begin
          icmp_acc_q <= SW'(icmp_acc_q[15:0]) + SW'(icmp_acc_q[SW-1:16]);
          ip_acc_q   <= SW'(ip_acc_q[15:0]) + SW'(ip_acc_q[SW-1:16]);
        end else begin
          img_q[ICMP_START+2] <= ~icmp_acc_q[15:8];
          img_q[ICMP_START+3] <= ~icmp_acc_q[7:0];
          img_q[24]           <= ~ip_acc_q[15:8];
          img_q[25]           <= ~ip_acc_q[7:0];
        end
      end
      S_WB: begin
        for (int k = 0; k < HDR_BYTES - 1; k++) begin
          img_q[k] <= img_q[k+1];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = out_tx_q;
  assign tx_last_o       = out_last_q;
  assign status_o        = out_status_q;
  assign reply_pending_o = out_pend_q;
  assign ping_seen_o     = out_seen_q;
  assign ping_source_o   = out_src_q;

`ifndef SYNTH
  // The reply never extends beyond the frame buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rl_q <= CW'(BUFFER_BYTES))
    else $error("reply length exceeds buffer");

  // The fill count never passes the buffer size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CW'(BUFFER_BYTES))
    else $error("fill count exceeds buffer");

  // The frame buffer is written only by a push or by the header write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_IDLE) || (state_q == S_WB)))
    else $error("frame buffer written in wrong state");

  // A frame outcome never carries a reply byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_NONE)) |-> (tx_byte_o == 8'h00))
    else $error("status and reply byte in one transfer");
`endif

endmodule
